### rtl/core/frm_pkg.sv
`default_nettype none

package frm_pkg;

  localparam int unsigned TICK_W = 64;
  localparam int unsigned TPS_W  = 30;
  localparam int unsigned FRM_W  = 32;
  localparam int unsigned RATE_W = 14;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned OPW    = 64;

  localparam logic [TPS_W-1:0]  TPS_RESET = 30'd268111856;
  localparam logic [RATE_W-1:0] RATE_MAX  = 14'd9999;
  localparam logic [OPW-1:0]    MS_SCALE  = 64'd10000;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } frm_op_e;

  typedef struct packed {
    logic    start;
    frm_op_e op;
  } frm_cmd_t;

endpackage

`default_nettype wire

### rtl/core/frm_alu.sv
`default_nettype none

module frm_alu import frm_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  frm_cmd_t       cmd_i,
  input  logic [OPW-1:0] opa_i,
  input  logic [OPW-1:0] opb_i,
  output logic           done_o,
  output logic [OPW-1:0] lo_o
);

  localparam int unsigned CNT_W = $clog2(OPW);

  typedef enum logic [5:0] {
    U_IDLE = 6'b000001,
    U_MUL  = 6'b000010,
    U_CHK  = 6'b000100,
    U_DIV  = 6'b001000,
    U_RND  = 6'b010000,
    U_INC  = 6'b100000
  } ustate_e;

  ustate_e          state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [OPW-1:0]   hi_q, hi_d;
  logic [OPW-1:0]   lo_q, lo_d;
  logic [OPW-1:0]   a_q, a_d;
  logic             done_q, done_d;

  logic [OPW:0]     add_x, add_y;
  logic             add_sub;
  logic [OPW+1:0]   sum;
  logic             ge;
  logic             last;

  // single shared add/subtract path, bit OPW+1 is the no-borrow flag
  assign sum  = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (OPW+2)'(add_sub);
  assign ge   = sum[OPW+1];
  assign last = (cnt_q == CNT_W'(OPW - 1));

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_q)
      U_MUL: begin
        add_x = {1'b0, hi_q};
        add_y = lo_q[0] ? {1'b0, a_q} : '0;
      end
      U_CHK: begin
        add_x   = {1'b0, hi_q};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      U_DIV: begin
        add_x   = {hi_q, lo_q[OPW-1]};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      U_RND: begin
        add_x   = {hi_q, 1'b0};
        add_y   = {1'b0, a_q};
        add_sub = 1'b1;
      end
      U_INC: begin
        add_x = {1'b0, lo_q};
        add_y = (OPW+1)'(1);
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    a_d     = a_q;
    done_d  = 1'b0;
    case (state_q)
      U_IDLE: begin
        if (cmd_i.start) begin
          a_d   = opa_i;
          cnt_d = '0;
          if (cmd_i.op == OP_MUL) begin
            hi_d    = '0;
            lo_d    = opb_i;
            state_d = U_MUL;
          end else begin
            state_d = U_CHK;
          end
        end
      end
      U_MUL: begin
        hi_d  = sum[OPW:1];
        lo_d  = {sum[0], lo_q[OPW-1:1]};
        cnt_d = CNT_W'(cnt_q + 1'b1);
        if (last) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      U_CHK: begin
        // quotient would not fit or divisor is zero
        if (ge) begin
          lo_d    = '1;
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          state_d = U_DIV;
        end
      end
      U_DIV: begin
        hi_d  = ge ? sum[OPW-1:0] : add_x[OPW-1:0];
        lo_d  = {lo_q[OPW-2:0], ge};
        cnt_d = CNT_W'(cnt_q + 1'b1);
        if (last) begin
          state_d = U_RND;
        end
      end
      U_RND: begin
        if (ge) begin
          state_d = U_INC;
        end else begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end
      end
      U_INC: begin
        lo_d    = sum[OPW] ? '1 : sum[OPW-1:0];
        done_d  = 1'b1;
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    a_q  <= a_d;
  end

  assign done_o = done_q;
  assign lo_o   = lo_q;

endmodule

`default_nettype wire

### rtl/core/frame_rate_meter_unit.sv
// frame rate meter: each input transaction is the timestamp of one finished frame. the first
// stamp, a stamp that goes backwards or a gap longer than five seconds restarts measurement;
// a repeated stamp is ignored. once a window of at least one second has gone by the block
// reports frames per second in tenths, mean and worst frame time in tenths of ms, all rounded
// to nearest, and opens a new window. exactly one output transaction per input transaction.
// an item that closes the window runs four shift-add multiplies and three restoring divides,
// each a 64-step loop of the shared add/subtract unit. input is not taken while an item is in
// work. ticks_per_second is written through cfg_wr_en_i / cfg_wr_data_i; the user must write
// it only while idle, as the block itself does not enforce this.
`default_nettype none

module frame_rate_meter_unit import frm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [TICK_W-1:0] s_axis_tdata_i,   // frame_tick
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // window_done, stats_valid, rate_tenths,
                                              // mean_ms_tenths, worst_ms_tenths
  input  logic              cfg_wr_en_i,
  input  logic [TPS_W-1:0]  cfg_wr_data_i     // ticks_per_second
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_EVAL      = 11'b00000000010,
    S_CHECK     = 11'b00000000100,
    S_WIN       = 11'b00000001000,
    S_MUL_RATE  = 11'b00000010000,
    S_DIV_RATE  = 11'b00000100000,
    S_MUL_DEN   = 11'b00001000000,
    S_MUL_MEAN  = 11'b00010000000,
    S_DIV_MEAN  = 11'b00100000000,
    S_MUL_WORST = 11'b01000000000,
    S_DIV_WORST = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   issue_q, issue_d;

  logic [TPS_W-1:0]  tps_q, tps_d;
  logic [TICK_W-1:0] tick_q, tick_d;
  logic [TICK_W-1:0] prev_q, prev_d;
  logic [TICK_W-1:0] wb_q, wb_d;
  logic [TICK_W-1:0] interval_q, interval_d;
  logic              borrow_q, borrow_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic [OPW-1:0]    den_q, den_d;
  logic [FRM_W-1:0]  frames_q, frames_d;
  logic [FRM_W-1:0]  longest_q, longest_d;
  logic              started_q, started_d;
  logic              have_q, have_d;
  logic              wdone_q, wdone_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [MS_W-1:0]   mean_q, mean_d;
  logic [MS_W-1:0]   worst_q, worst_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  logic [TPS_W+2:0]  tps5;
  logic [TPS_W+3:0]  tps10;
  logic              restart;
  logic              out_load;

  frm_cmd_t          alu_cmd;
  logic [OPW-1:0]    alu_opa, alu_opb;
  logic              alu_done;
  logic [OPW-1:0]    alu_lo;
  logic [RATE_W-1:0] rate_sat;
  logic [MS_W-1:0]   ms_sat;

  assign tps5  = (TPS_W+3)'({tps_q, 2'b00}) + (TPS_W+3)'(tps_q);
  assign tps10 = (TPS_W+4)'({tps_q, 3'b000}) + (TPS_W+4)'({tps_q, 1'b0});

  assign restart  = !started_q || borrow_q || (interval_q > TICK_W'(tps5));
  assign out_load = fin_q && (!m_valid_q || m_axis_tready_i);

  assign rate_sat = (alu_lo > OPW'(RATE_MAX)) ? RATE_MAX : alu_lo[RATE_W-1:0];
  assign ms_sat   = (alu_lo[OPW-1:MS_W] != '0) ? '1 : alu_lo[MS_W-1:0];

  always_comb begin
    alu_cmd.start = issue_q;
    alu_cmd.op    = OP_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    case (state_q)
      S_MUL_RATE: begin
        alu_opa = OPW'(frames_q);
        alu_opb = OPW'(tps10);
      end
      S_DIV_RATE: begin
        alu_cmd.op = OP_DIV;
        alu_opa    = elapsed_q;
      end
      S_MUL_DEN: begin
        alu_opa = OPW'(frames_q);
        alu_opb = OPW'(tps_q);
      end
      S_MUL_MEAN: begin
        alu_opa = elapsed_q;
        alu_opb = MS_SCALE;
      end
      S_DIV_MEAN: begin
        alu_cmd.op = OP_DIV;
        alu_opa    = den_q;
      end
      S_MUL_WORST: begin
        alu_opa = OPW'(longest_q);
        alu_opb = MS_SCALE;
      end
      S_DIV_WORST: begin
        alu_cmd.op = OP_DIV;
        alu_opa    = OPW'(tps_q);
      end
      default: begin
        alu_opa = '0;
      end
    endcase
  end

  frm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (alu_cmd),
    .opa_i  (alu_opa),
    .opb_i  (alu_opb),
    .done_o (alu_done),
    .lo_o   (alu_lo)
  );

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    issue_d    = 1'b0;
    tps_d      = cfg_wr_en_i ? cfg_wr_data_i : tps_q;
    tick_d     = tick_q;
    prev_d     = prev_q;
    wb_d       = wb_q;
    interval_d = interval_q;
    borrow_d   = borrow_q;
    elapsed_d  = elapsed_q;
    den_d      = den_q;
    frames_d   = frames_q;
    longest_d  = longest_q;
    started_d  = started_q;
    have_d     = have_q;
    wdone_d    = wdone_q;
    rate_d     = rate_q;
    mean_d     = mean_q;
    worst_d    = worst_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = have_q ? {worst_q, mean_q, rate_q, 1'b1, wdone_q}
                         : {(OUT_W-1)'(0), wdone_q};
      fin_d     = 1'b0;
      state_d   = S_IDLE;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i && !fin_q) begin
          tick_d  = s_axis_tdata_i;
          wdone_d = 1'b0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        {borrow_d, interval_d} = {1'b0, tick_q} - {1'b0, prev_q};
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (restart) begin
          prev_d    = tick_q;
          wb_d      = tick_q;
          frames_d  = '0;
          longest_d = '0;
          rate_d    = '0;
          mean_d    = '0;
          worst_d   = '0;
          started_d = 1'b1;
          have_d    = 1'b0;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end else if (interval_q == '0) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          prev_d = tick_q;
          if (frames_q != '1) begin
            frames_d = frames_q + 1'b1;
          end
          if (interval_q > TICK_W'(longest_q)) begin
            longest_d = (interval_q[TICK_W-1:FRM_W] != '0) ? '1 : interval_q[FRM_W-1:0];
          end
          elapsed_d = tick_q - wb_q;
          state_d   = S_WIN;
        end
      end
      S_WIN: begin
        if (elapsed_q < TICK_W'(tps_q)) begin
          fin_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          issue_d = 1'b1;
          state_d = S_MUL_RATE;
        end
      end
      S_MUL_RATE: begin
        if (alu_done) begin
          issue_d = 1'b1;
          state_d = S_DIV_RATE;
        end
      end
      S_DIV_RATE: begin
        if (alu_done) begin
          rate_d  = rate_sat;
          issue_d = 1'b1;
          state_d = S_MUL_DEN;
        end
      end
      S_MUL_DEN: begin
        if (alu_done) begin
          den_d   = alu_lo;
          issue_d = 1'b1;
          state_d = S_MUL_MEAN;
        end
      end
      S_MUL_MEAN: begin
        if (alu_done) begin
          issue_d = 1'b1;
          state_d = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        if (alu_done) begin
          mean_d  = ms_sat;
          issue_d = 1'b1;
          state_d = S_MUL_WORST;
        end
      end
      S_MUL_WORST: begin
        if (alu_done) begin
          issue_d = 1'b1;
          state_d = S_DIV_WORST;
        end
      end
      S_DIV_WORST: begin
        if (alu_done) begin
          worst_d   = ms_sat;
          have_d    = 1'b1;
          frames_d  = '0;
          longest_d = '0;
          wb_d      = tick_q;
          wdone_d   = 1'b1;
          fin_d     = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fin_q     <= 1'b0;
      issue_q   <= 1'b0;
      tps_q     <= TPS_RESET;
      started_q <= 1'b0;
      have_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fin_q     <= fin_d;
      issue_q   <= issue_d;
      tps_q     <= tps_d;
      started_q <= started_d;
      have_q    <= have_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q     <= tick_d;
    prev_q     <= prev_d;
    wb_q       <= wb_d;
    interval_q <= interval_d;
    borrow_q   <= borrow_d;
    elapsed_q  <= elapsed_d;
    den_q      <= den_d;
    frames_q   <= frames_d;
    longest_q  <= longest_d;
    wdone_q    <= wdone_d;
    rate_q     <= rate_d;
    mean_q     <= mean_d;
    worst_q    <= worst_d;
    m_data_q   <= m_data_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && !fin_q;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // results only arrive while an arithmetic step is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_MUL_RATE || state_q == S_DIV_RATE || state_q == S_MUL_DEN ||
                  state_q == S_MUL_MEAN || state_q == S_DIV_MEAN ||
                  state_q == S_MUL_WORST || state_q == S_DIV_WORST))
    else $error("arithmetic result outside of a compute step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o && state_q == S_IDLE && !fin_q)
    else $error("finished item not handed to the output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[1]) |-> (m_axis_tdata_o[OUT_W-1:2] == '0))
    else $error("result fields set without a completed measurement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |-> m_axis_tdata_o[1])
    else $error("window closed without a valid measurement");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[RATE_W+1:2] <= RATE_MAX))
    else $error("rate above its saturation limit");

endmodule

`default_nettype wire
